@@ rtl/core/ntcth_pkg.sv @@
`default_nettype none
package ntcth_pkg;

    // Field and register widths
    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned SUM_W     = 13;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned RES_W     = 20;
    localparam int unsigned TEMP_W    = 16;
    localparam int unsigned OUT_W     = 19;
    localparam int unsigned CFG_IDX_W = 8;

    // Defaults of the group length and the ADC range
    localparam int unsigned SAMPLES_DEF   = 5;
    localparam int unsigned ADC_FULL_DEF  = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERIES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T0      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA    = 8'd3;

    // Register reset values
    localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
    localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd32000;
    localparam logic [TEMP_W-1:0] T0_RST      = 16'd29815;
    localparam logic [TEMP_W-1:0] BETA_RST    = 16'd3350;

    // Arithmetic constants
    localparam int unsigned WORD_W    = 36;   // normalising window, top bit at 35
    localparam int unsigned MANT_W    = 31;   // Q30 mantissa in [1,2)
    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned EXP_W     = 6;
    localparam int unsigned LOG_W     = EXP_W + FRAC_BITS;
    localparam int unsigned QUO_BITS  = 18;
    localparam int unsigned ITER_W    = 5;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [6:0]  CENTI     = 7'd100;

    localparam logic [QUO_BITS-1:0]  Q_SAT_HIGH  = 18'd227315;
    localparam logic signed [OUT_W-1:0] KELVIN_OFS = 19'sd27315;
    localparam logic signed [OUT_W-1:0] OUT_LOW    = -19'sd8000;
    localparam logic signed [OUT_W-1:0] OUT_HIGH   = 19'sd200000;

    // Sequencer states
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_MULA = 14'b00000000000010,
        S_NORM = 14'b00000000000100,
        S_SQR  = 14'b00000000001000,
        S_MULB = 14'b00000000010000,
        S_SUB  = 14'b00000000100000,
        S_LN   = 14'b00000001000000,
        S_TMUL = 14'b00000010000000,
        S_P1   = 14'b00000100000000,
        S_NUM  = 14'b00001000000000,
        S_CHK  = 14'b00010000000000,
        S_DIV  = 14'b00100000000000,
        S_CONV = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

endpackage
`default_nettype wire

@@ rtl/core/ntc_thermistor_temperature.sv @@
// The item that completes a group starts a conversion: two log2 runs (multiply, normalise,
// 24 squaring steps), 6 arithmetic steps, an 18-step divide, then conversion and output;
// a zero, out-of-range or zero-register group goes straight to output, a high saturation skips the divide.
// Throughput: other items of a group are taken one per cycle; the input is stalled through the
// conversion and while a finished result waits. Synchronous active-low reset clears the sum,
// count and output valid and loads register defaults.
`default_nettype none
module ntc_thermistor_temperature #(
    parameter int unsigned SAMPLES        = ntcth_pkg::SAMPLES_DEF,
    parameter int unsigned ADC_FULL_SCALE = ntcth_pkg::ADC_FULL_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [ntcth_pkg::SAMPLE_W-1:0]        i_adc_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [ntcth_pkg::OUT_W-1:0]         o_temp_centi_celsius,
    output logic                                       o_zero_reading,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ntcth_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ntcth_pkg::RES_W-1:0]           i_cfg_data
);

    localparam int unsigned FULL = SAMPLES * ADC_FULL_SCALE;
    localparam int unsigned FW   = $clog2(FULL + 1);
    localparam int unsigned DW   = ((FW > ntcth_pkg::SUM_W) ? FW : ntcth_pkg::SUM_W) + 1;

    // Configuration registers
    logic [ntcth_pkg::RES_W-1:0]  r_series, r_nominal;
    logic [ntcth_pkg::TEMP_W-1:0] r_t0, r_beta;

    // Accumulator and sequencer
    ntcth_pkg::t_state r_state;
    logic [ntcth_pkg::SUM_W-1:0]   r_sum, r_s;
    logic [ntcth_pkg::COUNT_W-1:0] r_cnt;
    logic [ntcth_pkg::WORD_W-1:0]  r_w;
    logic [ntcth_pkg::EXP_W-1:0]   r_e;
    logic [ntcth_pkg::MANT_W-1:0]  r_m;
    logic [ntcth_pkg::FRAC_BITS-1:0] r_frac;
    logic [ntcth_pkg::ITER_W-1:0]  r_iter;
    logic                          r_second;
    logic [ntcth_pkg::LOG_W-1:0]   r_la, r_lb, r_mag;
    logic                          r_neg;
    logic [29:0]                   r_n;
    logic [45:0]                   r_t;
    logic [22:0]                   r_p1;
    logic [38:0]                   r_num;
    logic signed [48:0]            r_den;
    logic [63:0]                   r_rem;
    logic [64:0]                   r_dsh;
    logic [ntcth_pkg::QUO_BITS-1:0] r_q;
    logic signed [ntcth_pkg::OUT_W-1:0] r_res;
    logic                          r_zero;
    logic                          r_ov;

    // Combinational helpers
    logic [ntcth_pkg::SUM_W-1:0]   sum_n;
    logic [ntcth_pkg::COUNT_W:0]   cnt_n;
    logic [ntcth_pkg::SUM_W-1:0]   s_sel;
    logic signed [DW-1:0]          d_s;
    logic                          d_bad;
    logic [31:0]                   mul_x, mul_y;
    logic [63:0]                   mul_p;
    logic [31:0]                   sq;
    logic                          sq_bit;
    logic [ntcth_pkg::MANT_W-1:0]  m_next;
    logic [ntcth_pkg::FRAC_BITS-1:0] frac_next;
    logic signed [ntcth_pkg::LOG_W:0] l_diff;
    logic [63:0]                   ln_r;
    logic signed [48:0]            base_s, t_s, den_n;
    logic [63:0]                   n_div;
    logic                          q_over;
    logic                          div_ge;
    logic signed [16:0]            zero_t;
    logic signed [ntcth_pkg::OUT_W-1:0] zero_res, conv_res;
    logic                          out_free;
    logic                          in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ntcth_pkg::S_IDLE);
    assign o_valid     = r_ov;
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_ov || !i_stall;

    // Sum and count after this item
    assign sum_n = r_sum + ntcth_pkg::SUM_W'(i_adc_sample);
    assign cnt_n = {1'b0, r_cnt} + 1'b1;

    // Divider bottom term D = full - S
    assign s_sel = (r_state == ntcth_pkg::S_IDLE) ? sum_n : r_s;
    assign d_s   = $signed(DW'(FULL)) - $signed(DW'(s_sel));
    assign d_bad = d_s[DW-1] || (d_s == '0);

    // Zero-sum result: T0 - 273.15 K
    assign zero_t   = $signed({1'b0, r_t0}) - 17'sd27315;
    assign zero_res = (zero_t < 17'(ntcth_pkg::OUT_LOW)) ? ntcth_pkg::OUT_LOW
                                                         : ntcth_pkg::OUT_W'(zero_t);

    // Shared multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            ntcth_pkg::S_MULA: begin
                mul_x = 32'(r_series);
                mul_y = 32'(r_s);
            end
            ntcth_pkg::S_MULB: begin
                mul_x = 32'(r_nominal);
                mul_y = 32'(d_s[DW-2:0]);
            end
            ntcth_pkg::S_SQR: begin
                mul_x = 32'(r_m);
                mul_y = 32'(r_m);
            end
            ntcth_pkg::S_LN: begin
                mul_x = 32'(r_mag);
                mul_y = 32'(ntcth_pkg::LN2_Q30);
            end
            ntcth_pkg::S_TMUL: begin
                mul_x = 32'(r_t0);
                mul_y = 32'(r_n);
            end
            ntcth_pkg::S_P1: begin
                mul_x = 32'(r_beta);
                mul_y = 32'(ntcth_pkg::CENTI);
            end
            ntcth_pkg::S_NUM: begin
                mul_x = 32'(r_t0);
                mul_y = 32'(r_p1);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    // One squaring step of the log2 fraction
    assign sq        = mul_p[61:30];
    assign sq_bit    = sq[31];
    assign m_next    = sq_bit ? sq[31:1] : sq[30:0];
    assign frac_next = {r_frac[ntcth_pkg::FRAC_BITS-2:0], sq_bit};

    // Log difference and natural-log rounding
    assign l_diff = $signed({1'b0, r_la}) - $signed({1'b0, r_lb});
    assign ln_r   = mul_p + 64'h2000_0000;

    // Bottom of the Beta formula
    assign base_s = $signed({2'b00, r_p1, 24'd0});
    assign t_s    = $signed({3'b000, r_t});
    assign den_n  = r_neg ? (base_s - t_s) : (base_s + t_s);

    // Rounded dividend and overflow check
    assign n_div  = 64'({r_num, 24'd0}) + 64'(r_den[47:1]);
    assign q_over = {3'b000, n_div} >= {1'b0, r_den[47:0], 18'd0};
    assign div_ge = {1'b0, r_rem} >= r_dsh;

    // Kelvin to Celsius with saturation
    always_comb begin
        if (r_q >= ntcth_pkg::Q_SAT_HIGH) begin
            conv_res = ntcth_pkg::OUT_HIGH;
        end else begin
            conv_res = $signed({1'b0, r_q}) - ntcth_pkg::KELVIN_OFS;
            if (conv_res < ntcth_pkg::OUT_LOW) begin
                conv_res = ntcth_pkg::OUT_LOW;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series  <= ntcth_pkg::SERIES_RST;
            r_nominal <= ntcth_pkg::NOMINAL_RST;
            r_t0      <= ntcth_pkg::T0_RST;
            r_beta    <= ntcth_pkg::BETA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ntcth_pkg::REG_SERIES:  r_series  <= i_cfg_data;
                ntcth_pkg::REG_NOMINAL: r_nominal <= i_cfg_data;
                ntcth_pkg::REG_T0:      r_t0      <= i_cfg_data[ntcth_pkg::TEMP_W-1:0];
                ntcth_pkg::REG_BETA:    r_beta    <= i_cfg_data[ntcth_pkg::TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ntcth_pkg::S_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
            r_iter   <= '0;
            r_second <= 1'b0;
        end else begin
            if (r_ov && !i_stall && !((r_state == ntcth_pkg::S_DONE) && out_free)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ntcth_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (cnt_n == (ntcth_pkg::COUNT_W + 1)'(SAMPLES)) begin
                            r_sum <= '0;
                            r_cnt <= '0;
                            if (sum_n == '0) begin
                                r_state <= ntcth_pkg::S_DONE;
                            end else if (d_bad || (r_nominal == '0)) begin
                                r_state <= ntcth_pkg::S_DONE;
                            end else if (r_series == '0) begin
                                r_state <= ntcth_pkg::S_DONE;
                            end else begin
                                r_state <= ntcth_pkg::S_MULA;
                            end
                        end else begin
                            r_sum <= sum_n;
                            r_cnt <= cnt_n[ntcth_pkg::COUNT_W-1:0];
                        end
                    end
                end
                ntcth_pkg::S_MULA: begin
                    r_second <= 1'b0;
                    r_state  <= ntcth_pkg::S_NORM;
                end
                ntcth_pkg::S_MULB: begin
                    r_second <= 1'b1;
                    r_state  <= ntcth_pkg::S_NORM;
                end
                ntcth_pkg::S_NORM: begin
                    if (r_w[ntcth_pkg::WORD_W-1]) begin
                        r_iter  <= '0;
                        r_state <= ntcth_pkg::S_SQR;
                    end
                end
                ntcth_pkg::S_SQR: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ntcth_pkg::ITER_W'(ntcth_pkg::FRAC_BITS - 1)) begin
                        r_state <= r_second ? ntcth_pkg::S_SUB : ntcth_pkg::S_MULB;
                    end
                end
                ntcth_pkg::S_SUB:  r_state <= ntcth_pkg::S_LN;
                ntcth_pkg::S_LN:   r_state <= ntcth_pkg::S_TMUL;
                ntcth_pkg::S_TMUL: r_state <= ntcth_pkg::S_P1;
                ntcth_pkg::S_P1:   r_state <= ntcth_pkg::S_NUM;
                ntcth_pkg::S_NUM:  r_state <= ntcth_pkg::S_CHK;
                ntcth_pkg::S_CHK: begin
                    r_iter <= '0;
                    if (r_den[48] || (r_den == '0) || q_over) begin
                        r_state <= ntcth_pkg::S_DONE;
                    end else begin
                        r_state <= ntcth_pkg::S_DIV;
                    end
                end
                ntcth_pkg::S_DIV: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ntcth_pkg::ITER_W'(ntcth_pkg::QUO_BITS - 1)) begin
                        r_state <= ntcth_pkg::S_CONV;
                    end
                end
                ntcth_pkg::S_CONV: r_state <= ntcth_pkg::S_DONE;
                ntcth_pkg::S_DONE: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_state <= ntcth_pkg::S_IDLE;
                    end
                end
                default: r_state <= ntcth_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ntcth_pkg::S_IDLE: begin
                r_s    <= sum_n;
                r_zero <= (sum_n == '0);
                if (sum_n == '0) begin
                    r_res  <= zero_res;
                end else if (d_bad || (r_nominal == '0)) begin
                    r_res <= ntcth_pkg::OUT_LOW;
                end else begin
                    r_res <= ntcth_pkg::OUT_HIGH;
                end
            end
            ntcth_pkg::S_MULA, ntcth_pkg::S_MULB: begin
                r_w <= mul_p[ntcth_pkg::WORD_W-1:0];
                r_e <= ntcth_pkg::EXP_W'(ntcth_pkg::WORD_W - 1);
            end
            ntcth_pkg::S_NORM: begin
                if (r_w[ntcth_pkg::WORD_W-1]) begin
                    r_m    <= r_w[ntcth_pkg::WORD_W-1 -: ntcth_pkg::MANT_W];
                    r_frac <= '0;
                end else if (r_w[ntcth_pkg::WORD_W-1 -: 8] == '0) begin
                    r_w <= {r_w[ntcth_pkg::WORD_W-9:0], 8'd0};
                    r_e <= r_e - 6'd8;
                end else begin
                    r_w <= {r_w[ntcth_pkg::WORD_W-2:0], 1'b0};
                    r_e <= r_e - 6'd1;
                end
            end
            ntcth_pkg::S_SQR: begin
                r_m    <= m_next;
                r_frac <= frac_next;
                if (r_second) begin
                    r_lb <= {r_e, frac_next};
                end else begin
                    r_la <= {r_e, frac_next};
                end
            end
            ntcth_pkg::S_SUB: begin
                r_neg <= l_diff[ntcth_pkg::LOG_W];
                r_mag <= l_diff[ntcth_pkg::LOG_W] ? ntcth_pkg::LOG_W'(-l_diff)
                                                  : ntcth_pkg::LOG_W'(l_diff);
            end
            ntcth_pkg::S_LN:   r_n   <= ln_r[59:30];
            ntcth_pkg::S_TMUL: r_t   <= mul_p[45:0];
            ntcth_pkg::S_P1:   r_p1  <= mul_p[22:0];
            ntcth_pkg::S_NUM: begin
                r_num <= mul_p[38:0];
                r_den <= den_n;
            end
            ntcth_pkg::S_CHK: begin
                r_res <= ntcth_pkg::OUT_HIGH;
                r_rem <= n_div;
                r_dsh <= {r_den[47:0], 17'd0};
                r_q   <= '0;
            end
            ntcth_pkg::S_DIV: begin
                if (div_ge) begin
                    r_rem <= 64'({1'b0, r_rem} - r_dsh);
                end
                r_q   <= {r_q[ntcth_pkg::QUO_BITS-2:0], div_ge};
                r_dsh <= {1'b0, r_dsh[64:1]};
            end
            ntcth_pkg::S_CONV: r_res <= conv_res;
            ntcth_pkg::S_DONE: begin
                if (out_free) begin
                    o_temp_centi_celsius <= r_res;
                    o_zero_reading       <= r_zero;
                end
            end
            default: ;
        endcase
    end

    // Mantissa stays normalised through the squaring run
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntcth_pkg::S_SQR) |-> r_m[ntcth_pkg::MANT_W-1])
        else $error("log2 mantissa lost its leading one");

    // Divide runs exactly the quotient width
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntcth_pkg::S_DIV) |-> (r_iter < ntcth_pkg::ITER_W'(ntcth_pkg::QUO_BITS)))
        else $error("divide step count out of range");

    // Results stay inside the saturated range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_temp_centi_celsius >= ntcth_pkg::OUT_LOW)
                     && (o_temp_centi_celsius <= ntcth_pkg::OUT_HIGH)))
        else $error("temperature outside saturation limits");

    // Input held off during a conversion: no samples counted in the squaring or divide runs
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ntcth_pkg::S_DIV) || (r_state == ntcth_pkg::S_SQR)) |-> (r_cnt == '0))
        else $error("samples counted during a conversion");

endmodule
`default_nettype wire
